/* hdl/mms_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// mms_pkg
// Constants, function codes and sine/cosine drive table for the microstep
// motor sequencer.
// ---------------------------------------------------------------------------
package mms_pkg;

	localparam int MICROSTEPS = 32;
	localparam int POSITIONS  = 180;
	localparam int AMPLITUDE  = 400;

	localparam int MI_W      = $clog2(MICROSTEPS);
	localparam int POS_W     = 8;
	localparam int DUTY_W    = 9;
	localparam int CNT_W     = 16;
	localparam int OFF_W     = 11;
	localparam int TAB_N     = 32;
	localparam int TAB_W     = $clog2(TAB_N);
	localparam int QUARTER   = TAB_N / 4;
	localparam int FULL_SCALE = 400;

	localparam int RESET_POSITION = 90;
	localparam int HOLD_DUTY_A    = 0;
	localparam int HOLD_DUTY_B    = 100;
	localparam int DONE_MAX       = 15;
	localparam int SLOW_TH1       = 3;
	localparam int SLOW_TH2       = 6;
	localparam int SLOW_TH3       = 9;

	typedef enum logic [2:0] {
		FN_TICK       = 3'd0,
		FN_MOVE       = 3'd1,
		FN_SEEK_SHORT = 3'd2,
		FN_SEEK_CW    = 3'd3,
		FN_SEEK_CCW   = 3'd4
	} func_t;

	typedef logic signed [11:0] sine_tab_t [TAB_N];

	typedef struct packed {
		logic [DUTY_W-1:0] duty;
		logic              pol;
	} coil_t;

	localparam int SINE_BASE [TAB_N] = '{
		0, 78, 153, 222, 283, 333, 370, 392, 400, 392, 370, 333, 283, 222, 153, 78,
		0, -78, -153, -222, -283, -333, -370, -392, -400, -392, -370, -333, -283,
		-222, -153, -78
	};

	function automatic sine_tab_t build_sine_tab();
		sine_tab_t t;
		for (int i = 0; i < TAB_N; i++) begin
			t[i] = 12'((SINE_BASE[i] * AMPLITUDE) / FULL_SCALE);
		end
		return t;
	endfunction

	localparam sine_tab_t SINE_TAB = build_sine_tab();

	// microstep index to table entry
	function automatic logic [TAB_W-1:0] tab_index(logic [MI_W-1:0] m);
		return TAB_W'((int'(m) * TAB_N) / MICROSTEPS);
	endfunction

	// negative values drive amplitude plus value with polarity set
	function automatic coil_t coil_drive(logic [TAB_W-1:0] idx);
		logic signed [11:0] v;
		coil_t c;
		v = SINE_TAB[idx];
		if (v >= 0) begin
			c.duty = v[DUTY_W-1:0];
			c.pol  = 1'b0;
		end else begin
			c.duty = DUTY_W'(AMPLITUDE + int'(v));
			c.pol  = 1'b1;
		end
		return c;
	endfunction

endpackage
`default_nettype wire

/* hdl/microstep_motor_sequencer.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// microstep_motor_sequencer
// One stepper channel: move commands and ticks in, coil PWM duties out.
// ---------------------------------------------------------------------------
// Takes one item per clock while item_stall is low and returns one result
// beat per item: the item waits in the input register, then the step, ramp and
// coil drive logic loads the state registers that also form the result.
// An input item can be taken while a result waits, since the input register
// acts as a skid stage. cfg_ready is always high; accel_enable should only
// be written with no item in flight.
module microstep_motor_sequencer
	import mms_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    item_valid,
	output logic                         item_stall,
	input  wire logic [2:0]              func,
	input  wire logic signed [CNT_W-1:0] steps,
	input  wire logic [POS_W-1:0]        target,
	output logic                         result_valid,
	input  wire logic                    result_stall,
	output logic [DUTY_W-1:0]            duty_a,
	output logic                         pol_a,
	output logic [DUTY_W-1:0]            duty_b,
	output logic                         pol_b,
	output logic [POS_W-1:0]             cur_position,
	output logic                         moving,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic                    cfg_data
);

	logic                    item_valid_s1;
	logic [2:0]              func_s1;
	logic signed [CNT_W-1:0] steps_s1;
	logic [POS_W-1:0]        target_s1;

	logic                    result_valid_q;
	logic                    accel_q;
	logic signed [CNT_W-1:0] step_cnt_q, step_cnt_d;
	logic [MI_W-1:0]         micro_q, micro_d;
	logic [POS_W-1:0]        position_q, position_d;
	logic [3:0]              steps_done_q, steps_done_d;
	logic [1:0]              slow_div_q, slow_div_d;
	logic [1:0]              slow_cnt_q, slow_cnt_d;
	logic [DUTY_W-1:0]       duty_a_q, duty_a_d, duty_b_q, duty_b_d;
	logic                    pol_a_q, pol_a_d, pol_b_q, pol_b_d;

	logic                    advance;
	logic                    item_accept;
	logic signed [OFF_W-1:0] offset;
	logic signed [CNT_W-1:0] remaining;
	logic                    full_step;
	logic                    micro_step;
	coil_t                   coil_a, coil_b;

	assign advance     = item_valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall  = item_valid_s1 && result_valid_q && result_stall;
	assign item_accept = item_valid && !item_stall;
	assign cfg_ready   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (item_accept) begin
			item_valid_s1 <= 1'b1;
		end else if (advance) begin
			item_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_accept) begin
			func_s1   <= func;
			steps_s1  <= steps;
			target_s1 <= target;
		end
	end

	always_comb begin
		step_cnt_d   = step_cnt_q;
		micro_d      = micro_q;
		position_d   = position_q;
		steps_done_d = steps_done_q;
		slow_div_d   = slow_div_q;
		slow_cnt_d   = slow_cnt_q;
		duty_a_d     = duty_a_q;
		duty_b_d     = duty_b_q;
		pol_a_d      = pol_a_q;
		pol_b_d      = pol_b_q;
		full_step    = 1'b0;
		micro_step   = 1'b0;
		remaining    = '0;
		offset       = OFF_W'(target_s1) - OFF_W'(position_q);

		unique case (func_s1)
			FN_TICK: begin
				if (slow_cnt_q < slow_div_q) begin
					slow_cnt_d = slow_cnt_q + 2'd1;
				end else begin
					slow_cnt_d = '0;
					if (step_cnt_q == '0) begin
						duty_a_d = DUTY_W'(HOLD_DUTY_A);
						duty_b_d = DUTY_W'(HOLD_DUTY_B);
					end else if (step_cnt_q > 0) begin
						micro_step = 1'b1;
						if (micro_q >= MI_W'(MICROSTEPS - 1)) begin
							micro_d     = '0;
							step_cnt_d  = step_cnt_q - CNT_W'(1);
							position_d  = (position_q >= POS_W'(POSITIONS - 1)) ? '0
								: position_q + POS_W'(1);
							full_step   = 1'b1;
							remaining   = step_cnt_d;
						end else begin
							micro_d = micro_q + MI_W'(1);
						end
					end else begin
						micro_step = 1'b1;
						if (micro_q == '0) begin
							micro_d = MI_W'(MICROSTEPS - 1);
						end else if (micro_q == MI_W'(1)) begin
							micro_d     = '0;
							step_cnt_d  = step_cnt_q + CNT_W'(1);
							position_d  = (position_q == '0) ? POS_W'(POSITIONS - 1)
								: position_q - POS_W'(1);
							full_step   = 1'b1;
							remaining   = -step_cnt_d;
						end else begin
							micro_d = micro_q - MI_W'(1);
						end
					end
				end
			end
			FN_MOVE: begin
				step_cnt_d   = steps_s1;
				steps_done_d = '0;
				slow_cnt_d   = '0;
			end
			FN_SEEK_SHORT, FN_SEEK_CW, FN_SEEK_CCW: begin
				priority if (func_s1 == FN_SEEK_SHORT) begin
					if (offset >= OFF_W'(POSITIONS / 2)) begin
						offset = offset - OFF_W'(POSITIONS);
					end else if (offset <= -OFF_W'(POSITIONS / 2)) begin
						offset = offset + OFF_W'(POSITIONS);
					end
				end else if (func_s1 == FN_SEEK_CW) begin
					if (offset < 0) offset = offset + OFF_W'(POSITIONS);
				end else begin
					if (offset > 0) offset = offset - OFF_W'(POSITIONS);
				end
				// a seek to where the pointer already is leaves everything alone
				if (offset != '0) begin
					step_cnt_d   = CNT_W'(offset);
					steps_done_d = '0;
					slow_cnt_d   = '0;
				end
			end
			default: begin
			end
		endcase

		if (full_step) begin
			if (steps_done_q < 4'(DONE_MAX)) steps_done_d = steps_done_q + 4'd1;
			if (!accel_q) begin
				slow_div_d = 2'd0;
			end else if (steps_done_d <= 4'(SLOW_TH1) || remaining <= SLOW_TH1) begin
				slow_div_d = 2'd3;
			end else if (steps_done_d <= 4'(SLOW_TH2) || remaining <= SLOW_TH2) begin
				slow_div_d = 2'd2;
			end else if (steps_done_d <= 4'(SLOW_TH3) || remaining <= SLOW_TH3) begin
				slow_div_d = 2'd1;
			end else begin
				slow_div_d = 2'd0;
			end
		end

		coil_a = coil_drive(tab_index(micro_d));
		coil_b = coil_drive(tab_index(micro_d) + TAB_W'(QUARTER));
		if (micro_step) begin
			duty_a_d = coil_a.duty;
			pol_a_d  = coil_a.pol;
			duty_b_d = coil_b.duty;
			pol_b_d  = coil_b.pol;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			accel_q        <= 1'b1;
			step_cnt_q     <= '0;
			micro_q        <= '0;
			position_q     <= POS_W'(RESET_POSITION);
			steps_done_q   <= '0;
			slow_div_q     <= '0;
			slow_cnt_q     <= '0;
			duty_a_q       <= '0;
			pol_a_q        <= 1'b0;
			duty_b_q       <= '0;
			pol_b_q        <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) accel_q <= cfg_data;
			if (advance) begin
				result_valid_q <= 1'b1;
				step_cnt_q     <= step_cnt_d;
				micro_q        <= micro_d;
				position_q     <= position_d;
				steps_done_q   <= steps_done_d;
				slow_div_q     <= slow_div_d;
				slow_cnt_q     <= slow_cnt_d;
				duty_a_q       <= duty_a_d;
				pol_a_q        <= pol_a_d;
				duty_b_q       <= duty_b_d;
				pol_b_q        <= pol_b_d;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// the state registers double as the result beat
	assign result_valid = result_valid_q;
	assign duty_a       = duty_a_q;
	assign pol_a        = pol_a_q;
	assign duty_b       = duty_b_q;
	assign pol_b        = pol_b_q;
	assign cur_position = position_q;
	assign moving       = (step_cnt_q != '0) || (micro_q != '0);

	a_position_range: assert property (@(posedge clk) disable iff (!arst_n)
		position_q < POS_W'(POSITIONS))
		else $error("position out of range");

	a_slow_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		slow_cnt_q <= slow_div_q)
		else $error("tick divider count beyond divisor");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_stall |=>
			$stable(step_cnt_q) && $stable(micro_q) && $stable(position_q))
		else $error("motor state moved while result stalled");

endmodule
`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Checks the microstep motor sequencer against a cycle-free model of the
// stepper channel: move and seek commands, ticks through the ramped and
// unramped microstep sequence, and the coil drive, position and moving flag
// of every result beat. Both channels see random gaps and stalls.
// ---------------------------------------------------------------------------
module testbench
	import mms_pkg::*;
();

	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_LEN    = 300;
	localparam int HOLD_EVERY  = 2500;

	typedef struct packed {
		logic [2:0]              fn;
		logic signed [CNT_W-1:0] steps;
		logic [POS_W-1:0]        target;
	} motor_cmd_t;

	typedef struct packed {
		logic [DUTY_W-1:0] duty_a;
		logic              pol_a;
		logic [DUTY_W-1:0] duty_b;
		logic              pol_b;
		logic [POS_W-1:0]  pos;
		logic              moving;
	} coil_drive_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic [2:0] func = '0;
	logic signed [CNT_W-1:0] steps = '0;
	logic [POS_W-1:0] target = '0;
	logic result_stall = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_data = 1'b0;
	wire item_stall, result_valid, cfg_ready;
	wire [DUTY_W-1:0] duty_a, duty_b;
	wire pol_a, pol_b, moving;
	wire [POS_W-1:0] cur_position;

	motor_cmd_t  cmd_queue[$];
	coil_drive_t drive_expected[$];
	int errors = 0;
	int items_sent = 0;
	int results_seen = 0;
	int quiet_cycles = 0;
	logic item_took = 1'b0;
	int in_gap = 0;
	int in_calm = 0;
	int out_wait = 0;
	int out_calm = 0;
	int hold_left = 0;
	int hold_at = 1500;

	// model state
	bit accel_on;
	int step_left, micro, ptr_pos, done_cnt, ramp_div, ramp_cnt;
	logic [DUTY_W:0] coil_a, coil_b;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	microstep_motor_sequencer i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.func(func),
		.steps(steps),
		.target(target),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.duty_a(duty_a),
		.pol_a(pol_a),
		.duty_b(duty_b),
		.pol_b(pol_b),
		.cur_position(cur_position),
		.moving(moving),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	function automatic int pick_wait();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	// one period of the drive waveform, 32 entries, quarter-wave symmetric
	function automatic logic [DUTY_W:0] coil_level(int entry);
		int k, q, m, v;
		k = entry % 32;
		q = k % 16;
		m = (q <= 8) ? q : 16 - q;
		case (m)
			0: v = 0;
			1: v = 78;
			2: v = 153;
			3: v = 222;
			4: v = 283;
			5: v = 333;
			6: v = 370;
			7: v = 392;
			default: v = 400;
		endcase
		if (k >= 16)
			v = -v;
		v = (v * AMPLITUDE) / FULL_SCALE;
		if (v >= 0)
			return {DUTY_W'(v), 1'b0};
		return {DUTY_W'(AMPLITUDE + v), 1'b1};
	endfunction

	task automatic load_count(input int n);
		step_left = n;
		done_cnt = 0;
		ramp_cnt = 0;
	endtask

	task automatic step_finished(input int remaining);
		if (done_cnt < DONE_MAX)
			done_cnt++;
		if (!accel_on)
			ramp_div = 0;
		else if (done_cnt <= SLOW_TH1 || remaining <= SLOW_TH1)
			ramp_div = 3;
		else if (done_cnt <= SLOW_TH2 || remaining <= SLOW_TH2)
			ramp_div = 2;
		else if (done_cnt <= SLOW_TH3 || remaining <= SLOW_TH3)
			ramp_div = 1;
		else
			ramp_div = 0;
	endtask

	task automatic advance_motor(input motor_cmd_t c, output coil_drive_t r);
		int offset, entry;
		offset = int'(c.target) - ptr_pos;
		case (c.fn)
			FN_TICK: begin
				if (ramp_cnt < ramp_div) begin
					ramp_cnt++;
				end else begin
					ramp_cnt = 0;
					if (step_left == 0) begin
						coil_a[DUTY_W:1] = DUTY_W'(HOLD_DUTY_A);
						coil_b[DUTY_W:1] = DUTY_W'(HOLD_DUTY_B);
					end else begin
						if (step_left > 0) begin
							if (micro >= MICROSTEPS - 1) begin
								micro = 0;
								step_left--;
								ptr_pos = (ptr_pos >= POSITIONS - 1) ? 0 : ptr_pos + 1;
								step_finished(step_left);
							end else begin
								micro++;
							end
						end else if (micro == 0) begin
							micro = MICROSTEPS - 1;
						end else if (micro == 1) begin
							micro = 0;
							step_left++;
							ptr_pos = (ptr_pos == 0) ? POSITIONS - 1 : ptr_pos - 1;
							step_finished(-step_left);
						end else begin
							micro--;
						end
						entry = (micro * 32) / MICROSTEPS;
						coil_a = coil_level(entry);
						coil_b = coil_level(entry + 8);
					end
				end
			end
			FN_MOVE: load_count(int'($signed(c.steps)));
			FN_SEEK_SHORT: begin
				if (offset >= POSITIONS / 2)
					offset -= POSITIONS;
				else if (offset <= -(POSITIONS / 2))
					offset += POSITIONS;
				if (offset != 0)
					load_count(offset);
			end
			FN_SEEK_CW: begin
				if (offset < 0)
					offset += POSITIONS;
				if (offset != 0)
					load_count(offset);
			end
			FN_SEEK_CCW: begin
				if (offset > 0)
					offset -= POSITIONS;
				if (offset != 0)
					load_count(offset);
			end
			default: ;
		endcase
		r.duty_a = coil_a[DUTY_W:1];
		r.pol_a  = coil_a[0];
		r.duty_b = coil_b[DUTY_W:1];
		r.pol_b  = coil_b[0];
		r.pos    = POS_W'(ptr_pos);
		r.moving = (step_left != 0) || (micro != 0);
	endtask

	task automatic flag_mismatch(input string what);
		if (errors < 40)
			$display("%0t: result %0d: %s", $time, results_seen, what);
		errors++;
	endtask

	// item driver
	always @(negedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (item_valid && !item_took) begin
			// stalled beat holds
		end else if (in_gap != 0) begin
			item_valid <= 1'b0;
			in_gap <= in_gap - 1;
		end else if (cmd_queue.size() != 0) begin
			item_valid <= 1'b1;
			func <= cmd_queue[0].fn;
			steps <= cmd_queue[0].steps;
			target <= cmd_queue[0].target;
			in_gap <= (in_calm != 0) ? 0 : pick_wait();
			if (in_calm != 0)
				in_calm <= in_calm - 1;
			else if ($urandom_range(0, 199) == 0)
				in_calm <= $urandom_range(50, 200);
		end else begin
			item_valid <= 1'b0;
		end
	end

	// result receiver stalls
	always @(negedge clk) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else if (hold_left != 0) begin
			result_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (results_seen >= hold_at) begin
			// long hold-off so the block backs up into its input
			result_stall <= 1'b1;
			hold_left <= HOLD_LEN;
			hold_at <= hold_at + HOLD_EVERY;
		end else if (out_wait != 0) begin
			result_stall <= 1'b1;
			out_wait <= out_wait - 1;
		end else if (out_calm != 0) begin
			result_stall <= 1'b0;
			out_calm <= out_calm - 1;
		end else begin
			result_stall <= 1'b0;
			out_wait <= pick_wait();
			if ($urandom_range(0, 99) == 0)
				out_calm <= $urandom_range(50, 200);
		end
	end

	// monitor: predict on each accepted item, check each accepted result
	always @(posedge clk) begin
		motor_cmd_t c;
		coil_drive_t e;
		if (arst_n) begin
			item_took <= item_valid && !item_stall;
			if (item_valid && !item_stall) begin
				c = cmd_queue.pop_front();
				advance_motor(c, e);
				drive_expected.push_back(e);
			end
			if (result_valid && !result_stall) begin
				if (drive_expected.size() == 0) begin
					flag_mismatch("result beat with nothing expected");
				end else begin
					e = drive_expected.pop_front();
					if (duty_a !== e.duty_a)
						flag_mismatch($sformatf("duty_a %0d, want %0d", duty_a, e.duty_a));
					if (pol_a !== e.pol_a)
						flag_mismatch($sformatf("pol_a %0b, want %0b", pol_a, e.pol_a));
					if (duty_b !== e.duty_b)
						flag_mismatch($sformatf("duty_b %0d, want %0d", duty_b, e.duty_b));
					if (pol_b !== e.pol_b)
						flag_mismatch($sformatf("pol_b %0b, want %0b", pol_b, e.pol_b));
					if (cur_position !== e.pos)
						flag_mismatch($sformatf("cur_position %0d, want %0d",
							cur_position, e.pos));
					if (moving !== e.moving)
						flag_mismatch($sformatf("moving %0b, want %0b", moving, e.moving));
				end
				results_seen++;
			end
		end
	end

	// watchdog on handshake activity
	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall)
				|| (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic push_item(input logic [2:0] fn, input logic signed [CNT_W-1:0] s,
			input logic [POS_W-1:0] t);
		motor_cmd_t c;
		c.fn = fn;
		c.steps = s;
		c.target = t;
		cmd_queue.push_back(c);
		items_sent++;
	endtask

	// ticks carry random don't-care fields
	task automatic push_ticks(input int n);
		for (int i = 0; i < n; i++)
			push_item(FN_TICK, CNT_W'($urandom), POS_W'($urandom));
	endtask

	// upper bound of ticks for n full steps, including a slow first step
	function automatic int settle_ticks(int n);
		return accel_on ? n * 128 + 160 : n * 32 + 160;
	endfunction

	task automatic settle();
		while (cmd_queue.size() != 0 || drive_expected.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_accel(input logic v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		accel_on = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_sequence();
		int r, n, d, tgt, t;
		logic [2:0] fn;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			// unused function codes
			push_item(3'(FN_SEEK_CCW) + 3'($urandom_range(1, 3)), CNT_W'($urandom),
				POS_W'($urandom));
		end else if (r < 16) begin
			// any command with full-range fields, usually cut short
			push_item(3'($urandom_range(FN_MOVE, FN_SEEK_CCW)), CNT_W'($urandom),
				POS_W'($urandom));
			push_ticks($urandom_range(0, 60));
		end else begin
			fn = 3'($urandom_range(FN_MOVE, FN_SEEK_CCW));
			n = 3;
			d = 0;
			case (fn)
				FN_MOVE: n = $urandom_range(0, 3);
				FN_SEEK_SHORT: d = int'($urandom_range(0, 6)) - 3;
				FN_SEEK_CW: d = $urandom_range(0, 3);
				default: d = -int'($urandom_range(0, 3));
			endcase
			tgt = (ptr_pos + d + POSITIONS) % POSITIONS;
			// target past the end of travel, same place by the short route
			if (fn == FN_SEEK_SHORT && tgt < 76 && $urandom_range(0, 9) == 0)
				tgt += POSITIONS;
			push_item(fn, $urandom_range(0, 1) ? CNT_W'(n) : -CNT_W'(n), POS_W'(tgt));
			t = settle_ticks(n);
			if ($urandom_range(0, 9) < 6)
				push_ticks(t);
			else
				push_ticks($urandom_range(0, t));
		end
	endtask

	initial begin
		int budget, n;
		accel_on = 1'b1;
		step_left = 0;
		micro = 0;
		ptr_pos = RESET_POSITION;
		done_cnt = 0;
		ramp_div = 0;
		ramp_cnt = 0;
		coil_a = '0;
		coil_b = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_accel(1'b1);
		// holding drive, unused codes, zero moves and zero seeks
		push_item(FN_TICK, '0, '0);
		push_item(3'(FN_SEEK_CCW) + 3'd1, 16'sh7fff, 8'hff);
		push_item(3'(FN_SEEK_CCW) + 3'd2, 16'sh8000, 8'h00);
		push_item(3'(FN_SEEK_CCW) + 3'd3, 16'sh5555, 8'haa);
		push_item(FN_MOVE, '0, '0);
		push_item(FN_SEEK_SHORT, '0, 8'(RESET_POSITION));
		push_item(FN_SEEK_CW, '0, 8'(RESET_POSITION));
		push_item(FN_SEEK_CCW, '0, 8'(RESET_POSITION));
		// half-turn ties, target past the end, route wrap in each direction
		push_item(FN_SEEK_SHORT, '0, 8'd0);
		push_item(FN_SEEK_SHORT, '0, 8'd180);
		push_item(FN_SEEK_SHORT, '0, 8'd255);
		push_item(FN_SEEK_CW, '0, 8'd89);
		push_item(FN_SEEK_CCW, '0, 8'd91);
		push_item(FN_SEEK_CW, '0, 8'd0);
		push_item(FN_MOVE, 16'sh7fff, '0);
		push_item(FN_MOVE, 16'sh8000, '0);
		// back off part of a step, then reverse through the same microsteps
		push_item(FN_MOVE, -16'sd1, '0);
		push_ticks(3);
		push_item(FN_MOVE, 16'sd1, '0);
		push_ticks(5);
		settle();

		write_accel(1'b0);
		budget = items_sent + 200;
		while (items_sent < budget) begin
			settle();
			random_sequence();
		end
		settle();
		// long clockwise run at full rate
		n = 10;
		push_item(FN_SEEK_CW, '0, POS_W'((ptr_pos + n) % POSITIONS));
		push_ticks(settle_ticks(n));
		settle();

		write_accel(1'b1);
		// long anticlockwise run, ramp runs down to full rate, step tally saturates
		push_item(FN_SEEK_CCW, '0, POS_W'((ptr_pos + 150) % POSITIONS));
		push_ticks(1200);
		budget = items_sent + 200;
		while (items_sent < budget) begin
			settle();
			random_sequence();
		end
		settle();
		repeat (10) @(posedge clk);

		if (errors == 0 && drive_expected.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
